// ----- src/mfd_pkg.sv -----
// Package for the multi-turn motor feedback decoder.
// Holds constants, register codes and the structs shared by the RTL modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfd_pkg;

  localparam int MFD_NUM_MOTORS      = 2;
  localparam int MFD_COUNTS_PER_TURN = 8192;
  localparam int MFD_ANG_W           = $clog2(MFD_COUNTS_PER_TURN);
  localparam int MFD_HALF_TURN       = MFD_COUNTS_PER_TURN / 2;

  localparam logic [10:0] MFD_BASE_ID_RESET   = 11'd513;
  localparam logic [31:0] MFD_POS_SCALE_RESET = 32'd171573;
  localparam logic [31:0] MFD_VEL_SCALE_RESET = 32'd449767923;

  typedef enum logic [1:0] {
    MFD_REG_BASE_ID   = 2'd0,
    MFD_REG_POS_SCALE = 2'd1,
    MFD_REG_VEL_SCALE = 2'd2
  } mfd_reg_t;

  // request into the unwrap stage
  typedef struct packed {
    logic        advance;
    logic [10:0] frame_id;
    logic [12:0] rotor_angle;
  } mfd_unwrap_req_t;

  // unwrap stage result
  typedef struct packed {
    logic               hit;
    logic               motor_lsb;
    logic signed [31:0] rel;
  } mfd_unwrap_res_t;

endpackage

`default_nettype wire

// ----- src/mfd_unwrap.sv -----
// Per-motor angle unwrap, saturating turn count and zero latch.
// Depends on mfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfd_unwrap #(
  parameter int NUM_MOTORS = mfd_pkg::MFD_NUM_MOTORS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [10:0]            base_id,
  input  wire mfd_pkg::mfd_unwrap_req_t req,
  output mfd_pkg::mfd_unwrap_res_t    res
);

  localparam int IdxW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int AngW = mfd_pkg::MFD_ANG_W;
  localparam logic signed [AngW:0] HalfPos = (AngW + 1)'(mfd_pkg::MFD_HALF_TURN);
  localparam logic signed [AngW:0] HalfNeg = -HalfPos;

  logic [AngW-1:0]     prev_angle_r [NUM_MOTORS];
  logic signed [15:0]  turn_r       [NUM_MOTORS];
  logic signed [31:0]  zero_r       [NUM_MOTORS];
  logic                latched_r;

  logic [11:0]         offset;
  logic                hit;
  logic [IdxW-1:0]     m;
  logic [AngW-1:0]     angle;
  logic signed [AngW:0] diff;
  logic signed [15:0]  turn_nxt;
  logic signed [31:0]  absolute;
  logic                upd;

  assign offset = {1'b0, req.frame_id} - {1'b0, base_id};
  assign hit    = !offset[11] && (offset[10:0] < 11'(NUM_MOTORS));
  assign m      = offset[IdxW-1:0];
  assign angle  = AngW'(req.rotor_angle % mfd_pkg::MFD_COUNTS_PER_TURN);
  assign diff   = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_r[m]});
  assign upd    = req.advance && hit;

  always_comb begin
    turn_nxt = turn_r[m];
    if (diff > HalfPos) begin
      if (turn_r[m] != 16'sh8000) turn_nxt = turn_r[m] - 16'sd1;
    end else if (diff < HalfNeg) begin
      if (turn_r[m] != 16'sh7fff) turn_nxt = turn_r[m] + 16'sd1;
    end
  end

  // count * turn + angle; turn is a power of two
  assign absolute = {{(32 - 16 - AngW){turn_nxt[15]}}, turn_nxt, angle};

  assign res.hit       = hit;
  assign res.motor_lsb = m[0];
  assign res.rel       = latched_r ? (absolute - zero_r[m]) : 32'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        prev_angle_r[i] <= '0;
        turn_r[i]       <= '0;
        zero_r[i]       <= '0;
      end
      latched_r <= 1'b0;
    end else if (upd) begin
      prev_angle_r[m] <= angle;
      turn_r[m]       <= turn_nxt;
      if (!latched_r) begin
        zero_r[m] <= absolute;
        if (m == IdxW'(NUM_MOTORS - 1)) latched_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/mfd_scale_q16.sv -----
// Signed value times unsigned Q16.16 scale, shifted right 16 (floor), saturated to 32 bits.
// Depends on nothing beyond the language.
`timescale 1ns / 1ps
`default_nettype none

module mfd_scale_q16 (
  input  wire logic signed [31:0] value,
  input  wire logic [31:0]        scale,
  output logic signed [31:0]      result
);

  logic signed [64:0] prod;

  assign prod = $signed(value) * $signed({1'b0, scale});

  always_comb begin
    if ((&prod[64:47]) || !(|prod[64:47])) result = prod[47:16];
    else if (prod[64])                     result = 32'sh8000_0000;
    else                                   result = 32'sh7fff_ffff;
  end

endmodule

`default_nettype wire

// ----- src/motor_feedback_multiturn_decoder.sv -----
// Top level: multi-turn motor feedback decoder.
// Path: an accepted item is registered in s1, then mid, then out before it reaches the outputs.
// Throughput: one item per cycle while out_ready stays high; the three-stage register pipeline sets it.
// Reset: synchronous, active low; clears turn counts, angles, zeros and the zero latch,
// and loads the configuration registers with their defaults. Depends on mfd_pkg,
// mfd_unwrap and mfd_scale_q16.
`timescale 1ns / 1ps
`default_nettype none

module motor_feedback_multiturn_decoder #(
  parameter int NUM_MOTORS = mfd_pkg::MFD_NUM_MOTORS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [10:0]        in_frame_id,
  input  wire logic [12:0]        in_rotor_angle,
  input  wire logic signed [15:0] in_speed_rpm,
  input  wire logic signed [15:0] in_current_raw,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_motor_index,
  output logic signed [31:0]      out_position_q16,
  output logic signed [31:0]      out_velocity_q16,
  output logic signed [15:0]      out_current_out
);

  logic [10:0] base_id_r;
  logic [31:0] pos_scale_r;
  logic [31:0] vel_scale_r;

  logic               s1_v_r;
  logic [10:0]        s1_id_r;
  logic [12:0]        s1_angle_r;
  logic signed [15:0] s1_rpm_r;
  logic signed [15:0] s1_cur_r;

  logic               mid_v_r;
  logic               mid_idx_r;
  logic signed [31:0] mid_rel_r;
  logic signed [15:0] mid_rpm_r;
  logic signed [15:0] mid_cur_r;

  logic               out_valid_r;
  logic               out_idx_r;
  logic signed [31:0] out_pos_r;
  logic signed [31:0] out_vel_r;
  logic signed [15:0] out_cur_r;

  logic can_out, can_mid, can_s1;
  mfd_pkg::mfd_unwrap_req_t uw_req;
  mfd_pkg::mfd_unwrap_res_t uw_res;
  logic signed [31:0] pos_q16, vel_q16;

  assign can_out  = !out_valid_r || out_ready;
  assign can_mid  = !mid_v_r || can_out;
  assign can_s1   = !s1_v_r || can_mid;
  assign in_ready = can_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r   <= mfd_pkg::MFD_BASE_ID_RESET;
      pos_scale_r <= mfd_pkg::MFD_POS_SCALE_RESET;
      vel_scale_r <= mfd_pkg::MFD_VEL_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (mfd_pkg::mfd_reg_t'(cfg_index))
        mfd_pkg::MFD_REG_BASE_ID:   base_id_r   <= cfg_wdata[10:0];
        mfd_pkg::MFD_REG_POS_SCALE: pos_scale_r <= cfg_wdata;
        mfd_pkg::MFD_REG_VEL_SCALE: vel_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign uw_req.advance     = s1_v_r && can_mid;
  assign uw_req.frame_id    = s1_id_r;
  assign uw_req.rotor_angle = s1_angle_r;

  mfd_unwrap #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_unwrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .base_id(base_id_r),
    .req    (uw_req),
    .res    (uw_res)
  );

  mfd_scale_q16 u_pos_scale (
    .value (mid_rel_r),
    .scale (pos_scale_r),
    .result(pos_q16)
  );

  mfd_scale_q16 u_vel_scale (
    .value ({{16{mid_rpm_r[15]}}, mid_rpm_r}),
    .scale (vel_scale_r),
    .result(vel_q16)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      mid_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (can_s1)  s1_v_r      <= in_valid;
      if (can_mid) mid_v_r     <= s1_v_r && uw_res.hit;
      if (can_out) out_valid_r <= mid_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && can_s1) begin
      s1_id_r    <= in_frame_id;
      s1_angle_r <= in_rotor_angle;
      s1_rpm_r   <= in_speed_rpm;
      s1_cur_r   <= in_current_raw;
    end
    if (s1_v_r && can_mid) begin
      mid_idx_r <= uw_res.motor_lsb;
      mid_rel_r <= uw_res.rel;
      mid_rpm_r <= s1_rpm_r;
      mid_cur_r <= s1_cur_r;
    end
    if (mid_v_r && can_out) begin
      out_idx_r <= mid_idx_r;
      out_pos_r <= pos_q16;
      out_vel_r <= vel_q16;
      out_cur_r <= mid_cur_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_motor_index  = out_idx_r;
  assign out_position_q16 = out_pos_r;
  assign out_velocity_q16 = out_vel_r;
  assign out_current_out  = out_cur_r;

endmodule

`default_nettype wire

// ----- src/mfd_checker.sv -----
// Port-level checker for the multi-turn motor feedback decoder, with its bind.
// Depends on motor_feedback_multiturn_decoder.
`timescale 1ns / 1ps
`default_nettype none

module mfd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_motor_index,
  input wire logic signed [31:0] out_position_q16,
  input wire logic signed [31:0] out_velocity_q16,
  input wire logic signed [15:0] out_current_out
);

  logic first_pending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) first_pending_r <= 1'b1;
    else if (out_valid && out_ready) first_pending_r <= 1'b0;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_index)
      && $stable(out_position_q16) && $stable(out_velocity_q16)
      && $stable(out_current_out))
    else $error("result item changed while stalled");

  a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side is ready");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_first_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_pending_r |-> out_position_q16 == 32'sd0)
    else $error("first result after reset not at zero position");

endmodule

bind motor_feedback_multiturn_decoder mfd_checker u_mfd_checker (.*);

`default_nettype wire
